// ===== rtl/ansi_pkg.sv =====
package ansi_pkg;

    localparam int CHAR_W = 8;
    localparam int COLOR_W = 4;
    localparam int COUNT_W = 7;

    localparam logic [CHAR_W-1:0] CHAR_ESC = 8'h1B;
    localparam logic [CHAR_W-1:0] CHAR_CSI = 8'h5B;
    localparam logic [CHAR_W-1:0] CHAR_SGR = 8'h6D;
    localparam logic [CHAR_W-1:0] CHAR_SEP = 8'h3B;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

    localparam logic [CHAR_W-1:0] NUM_FORE_LO = 8'd30;
    localparam logic [CHAR_W-1:0] NUM_BACK_LO = 8'd40;
    localparam logic [CHAR_W-1:0] NUM_BACK_HI = 8'd50;

    localparam logic [COLOR_W-1:0] FORE_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;

    typedef struct packed {
        logic               show_valid;
        logic [CHAR_W-1:0]  show_char;
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
        logic               last;
    } result_t;

    // One or two results written into the output queue in the same cycle.
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

    // ANSI color index to CGA color index.
    function automatic logic [COLOR_W-1:0] cga_of_ansi(input logic [COLOR_W-1:0] idx);
        logic [COLOR_W-1:0] cga;
        unique case (idx)
            4'd0:    cga = 4'd0;
            4'd1:    cga = 4'd4;
            4'd2:    cga = 4'd2;
            4'd3:    cga = 4'd6;
            4'd4:    cga = 4'd1;
            4'd5:    cga = 4'd5;
            4'd6:    cga = 4'd3;
            4'd7:    cga = 4'd7;
            4'd8:    cga = 4'd8;
            4'd9:    cga = 4'd12;
            4'd10:   cga = 4'd10;
            4'd11:   cga = 4'd14;
            4'd12:   cga = 4'd9;
            4'd13:   cga = 4'd13;
            4'd14:   cga = 4'd11;
            default: cga = 4'd15;
        endcase
        return cga;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

    function automatic logic is_decimal(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
    endfunction

endpackage

// ===== rtl/ansi_parse_core.sv =====
module ansi_parse_core #(
    parameter int PARAM_LIMIT = 99
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            char_in,
    output ansi_pkg::push_t       push
);
    import ansi_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_SEQ    = 2'd2;
    localparam logic [1:0] MODE_OVER   = 2'd3;

    localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(PARAM_LIMIT);

    logic [1:0]         mode_reg, mode_next;
    logic [COUNT_W-1:0] param_count_reg, param_count_next;
    logic [CHAR_W-1:0]  number_acc_reg, number_acc_next;
    logic [COLOR_W-1:0] pend_fore_reg, pend_fore_next;
    logic [COLOR_W-1:0] pend_back_reg, pend_back_next;
    logic [COLOR_W-1:0] fore_reg, fore_next;
    logic [COLOR_W-1:0] back_reg, back_next;

    logic [COLOR_W-1:0] applied_fore;
    logic [COLOR_W-1:0] applied_back;
    logic [11:0]        acc_sum;
    logic [CHAR_W-1:0]  acc_sat;
    logic [CHAR_W-1:0]  num_off_fore;
    logic [CHAR_W-1:0]  num_off_back;

    // Effect of the gathered number on the pending colors.
    assign num_off_fore = number_acc_reg - NUM_FORE_LO;
    assign num_off_back = number_acc_reg - NUM_BACK_LO;

    always_comb
    begin
        applied_fore = pend_fore_reg;
        applied_back = pend_back_reg;
        if ((number_acc_reg >= NUM_FORE_LO) && (number_acc_reg < NUM_BACK_LO))
        begin
            applied_fore = cga_of_ansi(num_off_fore[COLOR_W-1:0]);
        end
        else if ((number_acc_reg >= NUM_BACK_LO) && (number_acc_reg < NUM_BACK_HI))
        begin
            applied_back = cga_of_ansi(num_off_back[COLOR_W-1:0]);
        end
    end

    // Times ten as two shifts plus the digit, then saturate at 255.
    assign acc_sum = {1'b0, number_acc_reg, 3'b000} + {3'b000, number_acc_reg, 1'b0}
                   + {4'b0000, char_in - CHAR_DIGIT_0};
    assign acc_sat = (acc_sum > 12'd255) ? 8'hFF : acc_sum[7:0];

    always_comb
    begin
        mode_next        = mode_reg;
        param_count_next = param_count_reg;
        number_acc_next  = number_acc_reg;
        pend_fore_next   = pend_fore_reg;
        pend_back_next   = pend_back_reg;
        fore_next        = fore_reg;
        back_next        = back_reg;
        push.push0       = 1'b0;
        push.push1       = 1'b0;
        push.res0        = '0;
        push.res1        = '0;

        if (accept)
        begin
            push.push0 = 1'b1;
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    if (char_in == CHAR_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        push.res0.show_valid = 1'b1;
                        push.res0.show_char  = char_in;
                    end
                end
                MODE_ESC:
                begin
                    if (char_in == CHAR_CSI)
                    begin
                        param_count_next = '0;
                        number_acc_next  = '0;
                        pend_fore_next   = fore_reg;
                        pend_back_next   = back_reg;
                        mode_next        = MODE_SEQ;
                    end
                    else
                    begin
                        // A lone escape is shown together with the byte after it.
                        mode_next            = MODE_NORMAL;
                        push.push1           = 1'b1;
                        push.res0.show_valid = 1'b1;
                        push.res0.show_char  = CHAR_ESC;
                        push.res1.show_valid = 1'b1;
                        push.res1.show_char  = char_in;
                    end
                end
                MODE_SEQ:
                begin
                    if (is_letter(char_in))
                    begin
                        if (char_in == CHAR_SGR)
                        begin
                            fore_next = applied_fore;
                            back_next = applied_back;
                        end
                        param_count_next = '0;
                        number_acc_next  = '0;
                        pend_fore_next   = (char_in == CHAR_SGR) ? applied_fore : fore_reg;
                        pend_back_next   = (char_in == CHAR_SGR) ? applied_back : back_reg;
                        mode_next        = MODE_NORMAL;
                    end
                    else if (param_count_reg >= LIMIT)
                    begin
                        mode_next = MODE_OVER;
                    end
                    else
                    begin
                        param_count_next = param_count_reg + 1'b1;
                        if (is_decimal(char_in))
                        begin
                            number_acc_next = acc_sat;
                        end
                        else if (char_in == CHAR_SEP)
                        begin
                            pend_fore_next  = applied_fore;
                            pend_back_next  = applied_back;
                            number_acc_next = '0;
                        end
                    end
                end
                default:
                begin
                    if (is_letter(char_in))
                    begin
                        param_count_next = '0;
                        number_acc_next  = '0;
                        pend_fore_next   = fore_reg;
                        pend_back_next   = back_reg;
                        mode_next        = MODE_NORMAL;
                    end
                end
            endcase

            push.res0.fore_color = fore_next;
            push.res0.back_color = back_next;
            push.res0.last       = ~push.push1;
            push.res1.fore_color = fore_next;
            push.res1.back_color = back_next;
            push.res1.last       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NORMAL;
            param_count_reg <= '0;
            number_acc_reg  <= '0;
            pend_fore_reg   <= FORE_RESET;
            pend_back_reg   <= BACK_RESET;
            fore_reg        <= FORE_RESET;
            back_reg        <= BACK_RESET;
        end
        else
        begin
            mode_reg        <= mode_next;
            param_count_reg <= param_count_next;
            number_acc_reg  <= number_acc_next;
            pend_fore_reg   <= pend_fore_next;
            pend_back_reg   <= pend_back_next;
            fore_reg        <= fore_next;
            back_reg        <= back_next;
        end
    end

endmodule

// ===== rtl/ansi_out_queue.sv =====
module ansi_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  ansi_pkg::push_t   push,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output ansi_pkg::result_t out_res
);
    import ansi_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;
    logic              pop;
    logic [CNT_W-1:0]  push_n;

    // Room for the two results that one input can cause.
    assign has_room     = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid    = (count_reg != '0);
    assign out_res      = entry_reg[rd_ptr_reg];
    assign pop          = out_valid & out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign push_n       = CNT_W'(push.push0) + CNT_W'(push.push1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_n - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            entry_reg[wr_ptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/ansi_color_escape_parser.sv =====
// Channel   Dir  Payload
// s_*       in   tdata[7:0] char_in
// m_*       out  tdata[7:0] show_char, [11:8] fore_color, [15:12] back_color;
//                tuser[0] show_valid; tlast marks the last result of one input byte
//
// One byte is taken per cycle while the queue has room; its parser state updates at the
// accepting edge and its results can leave on the following cycle. An escape followed
// by a byte other than '[' gives two results, both written into the queue together.
// A four-entry result queue separates the sides; input is taken while two slots are free.
// Reset is asynchronous and restores white on black with the parser in normal mode.
module ansi_color_escape_parser #(
    parameter int PARAM_LIMIT = 99
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] show_char, [11:8] fore_color, [15:12] back_color
    output logic [0:0]  m_tuser,   // [0] show_valid
    output logic        m_tlast
);
    import ansi_pkg::*;

    push_t   push;
    result_t out_res;
    logic    accept;

    assign accept = s_tvalid & s_tready;

    ansi_parse_core #(
        .PARAM_LIMIT (PARAM_LIMIT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .char_in (s_tdata),
        .push    (push)
    );

    ansi_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.back_color, out_res.fore_color, out_res.show_char};
    assign m_tuser = out_res.show_valid;
    assign m_tlast = out_res.last;

endmodule
